// ===== design/assert_macros.svh =====
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while arst_n is high.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cfe_pkg.sv =====
// Types and constants shared by the COBS frame encoder modules.
package cfe_pkg;

	localparam int MAX_FRAME_DEF = 255;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [8:0] FULL_DIST = 9'd255;
	localparam logic [7:0] FULL_CODE = 8'hFF;

	// Order of the writes that one queued item may carry.
	localparam logic [1:0] STEP_SPLIT = 2'd0;
	localparam logic [1:0] STEP_MAIN  = 2'd1;
	localparam logic [1:0] STEP_CODE  = 2'd2;
	localparam logic [1:0] STEP_DELIM = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       frame_end;
	} in_t;

	typedef struct packed {
		logic [8:0] write_addr;
		logic [7:0] write_data;
		logic       last_write;
		logic       frame_complete;
		logic [8:0] frame_length;
		logic       frame_overflow;
	} out_t;

	// Classified item: the writes it causes, in output order.
	typedef struct packed {
		logic       split_v;
		logic [8:0] split_addr;
		logic       main_v;
		logic [8:0] main_addr;
		logic [7:0] main_data;
		logic       end_v;
		logic [8:0] code_addr;
		logic [7:0] code_data;
		logic [8:0] delim_addr;
		logic [8:0] frame_len;
		logic       ovf;
	} cmd_t;

endpackage

// ===== design/cfe_front.sv =====
// Front part: tracks block pointers and turns each item into a write command.
module cfe_front
	import cfe_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  in_t  item,
	output logic push,
	output cmd_t cmd
);

	localparam logic [7:0] LIMIT = 8'((MAX_FRAME > 255) ? 255 : MAX_FRAME);

	logic [8:0] code_slot_q, next_slot_q;
	logic [7:0] bytes_taken_q;
	logic       overflow_seen_q;

	logic       taken, split;
	logic [8:0] span, span1, cs1, ns1, cs2, ns2, span2;
	logic       ovf_new;

	always_comb begin
		taken   = item.byte_present && (bytes_taken_q < LIMIT);
		ovf_new = overflow_seen_q || (item.byte_present && (bytes_taken_q >= LIMIT));
		span    = next_slot_q - code_slot_q;
		split   = taken && (span >= FULL_DIST);
		cs1     = split ? next_slot_q : code_slot_q;
		ns1     = split ? next_slot_q + 9'd1 : next_slot_q;
		span1   = split ? 9'd1 : span;

		cmd            = '0;
		cmd.split_v    = split;
		cmd.split_addr = code_slot_q;
		cmd.main_v     = taken;
		cs2            = code_slot_q;
		ns2            = next_slot_q;
		if (taken) begin
			ns2 = ns1 + 9'd1;
			if (item.data_byte == 8'd0) begin
				// A zero closes the open block; the next block's code sits after it.
				cmd.main_addr = cs1;
				cmd.main_data = span1[7:0];
				cs2           = ns1;
			end else begin
				cmd.main_addr = ns1;
				cmd.main_data = item.data_byte;
				cs2           = cs1;
			end
		end
		span2          = ns2 - cs2;
		cmd.end_v      = item.frame_end;
		cmd.code_addr  = cs2;
		cmd.code_data  = span2[7:0];
		cmd.delim_addr = ns2;
		cmd.frame_len  = ns2 + 9'd1;
		cmd.ovf        = ovf_new;
		push           = accept && (taken || item.frame_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_slot_q     <= 9'd0;
			next_slot_q     <= 9'd1;
			bytes_taken_q   <= 8'd0;
			overflow_seen_q <= 1'b0;
		end else if (accept) begin
			if (item.frame_end) begin
				code_slot_q     <= 9'd0;
				next_slot_q     <= 9'd1;
				bytes_taken_q   <= 8'd0;
				overflow_seen_q <= 1'b0;
			end else begin
				code_slot_q     <= cs2;
				next_slot_q     <= ns2;
				bytes_taken_q   <= taken ? bytes_taken_q + 8'd1 : bytes_taken_q;
				overflow_seen_q <= ovf_new;
			end
		end
	end

	`include "assert_macros.svh"

	`ASSERT_CLK(a_taken_bound, bytes_taken_q <= LIMIT, "byte count passed the frame limit")
	`ASSERT_CLK(a_code_before_next, code_slot_q < next_slot_q, "code slot not ahead of data")

endmodule

// ===== design/cfe_queue.sv =====
// Short command queue between the front and back parts.
module cfe_queue
	import cfe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	cmd_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`include "assert_macros.svh"

	`ASSERT_CLK(a_no_push_full, push |-> !full, "push into a full queue")
	`ASSERT_CLK(a_no_pop_empty, pop |-> !empty, "pop from an empty queue")

endmodule

// ===== design/cfe_back.sv =====
// Back part: steps through the writes of the head command into the output register.
module cfe_back
	import cfe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t head,
	input  logic empty,
	output logic pop,
	input  logic out_stall,
	output logic out_valid,
	output out_t out_item
);

	logic [1:0] sel_q;
	logic       valid_q;
	out_t       item_q;

	logic [3:0] mask;
	logic [1:0] pick;
	logic       found, more, load;
	out_t       nxt;

	always_comb begin
		mask  = {head.end_v, head.end_v, head.main_v, head.split_v};
		pick  = STEP_SPLIT;
		found = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (!found && mask[i] && (i >= int'(sel_q))) begin
				pick  = 2'(i);
				found = 1'b1;
			end
		end
		more = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (mask[i] && (i > int'(pick))) begin
				more = 1'b1;
			end
		end

		nxt                = '0;
		nxt.last_write     = !more;
		nxt.frame_overflow = head.ovf;
		unique case (pick)
			STEP_SPLIT: begin
				nxt.write_addr = head.split_addr;
				nxt.write_data = FULL_CODE;
			end
			STEP_MAIN: begin
				nxt.write_addr = head.main_addr;
				nxt.write_data = head.main_data;
			end
			STEP_CODE: begin
				nxt.write_addr = head.code_addr;
				nxt.write_data = head.code_data;
			end
			STEP_DELIM: begin
				nxt.write_addr     = head.delim_addr;
				nxt.write_data     = 8'd0;
				nxt.frame_complete = 1'b1;
				nxt.frame_length   = head.frame_len;
			end
			default: begin
				nxt.write_addr = head.split_addr;
				nxt.write_data = FULL_CODE;
			end
		endcase

		load = !valid_q || !out_stall;
		pop  = load && !empty && !more;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= STEP_SPLIT;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				sel_q <= more ? pick + 2'd1 : STEP_SPLIT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			item_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

	`include "assert_macros.svh"

	`ASSERT_CLK(a_delim_last, valid_q && item_q.frame_complete |-> item_q.last_write, "bad last")

endmodule

// ===== design/cobs_frame_encoder.sv =====
// COBS frame encoder: takes one raw byte per item and issues buffer writes of the
// stuffed frame; a byte that only extends its block costs one write, a byte that
// forces a 254-byte split adds one write, and a frame end adds the final code and
// delimiter writes, so an item causes up to four writes, while an idle item or a
// dropped byte causes none. A new item is taken every cycle while the four-entry
// command queue has room; the queue drains at one write per cycle while write_stall
// is low, which sets the sustained rate. Input bytes beyond MAX_FRAME (capped at
// 255) are dropped and flagged on frame_overflow.
module cobs_frame_encoder
	import cfe_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic byte_valid,
	output logic byte_stall,
	input  in_t  byte_item,
	output logic write_valid,
	input  logic write_stall,
	output out_t write_item
);

	logic accept, push, pop, empty, full;
	cmd_t cmd, head;

	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	cfe_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (byte_item),
		.push  (push),
		.cmd   (cmd)
	);

	cfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(cmd),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	cfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.out_stall(write_stall),
		.out_valid(write_valid),
		.out_item (write_item)
	);

endmodule
